// ===== rtl/psfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfp_pkg: shared types and constants of the phase scope frame plotter
// Item actions, register indexes, controller/datapath command and status
// structs, and the per-channel fade function.
// ----------------------------------------------------------------------------
package psfp_pkg;

    localparam int ZOOM_W    = 9;
    localparam int COLOR_W   = 24;
    localparam int SAMPLE_W  = 16;
    localparam int ADDR_IN_W = 14;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_POINT = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE   = 2'd3;

    localparam logic               RST_ENABLED = 1'b1;
    localparam logic [ZOOM_W-1:0]  RST_ZOOM    = 9'd100;
    localparam logic [COLOR_W-1:0] RST_AXIS    = 24'h404040;
    localparam logic [COLOR_W-1:0] RST_TRACE   = 24'h00FF00;

    typedef struct packed {
        logic pt_start;
        logic pt_scale;
        logic div_init;
        logic div_step;
        logic pt_write;
        logic sweep_rd;
        logic init_wr;
        logic sweep_clear;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
    } status_t;

    // floor(7*c/8) on each colour channel
    function automatic logic [COLOR_W-1:0] fade(input logic [COLOR_W-1:0] c);
        logic [10:0] r;
        logic [10:0] g;
        logic [10:0] b;
        r = {3'b000, c[23:16]} * 11'd7;
        g = {3'b000, c[15:8]} * 11'd7;
        b = {3'b000, c[7:0]} * 11'd7;
        return {r[10:3], g[10:3], b[10:3]};
    endfunction

endpackage

// ===== rtl/psfp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfp_ctrl: controller of the phase scope frame plotter
// Sequences the reset clearing pass, point mapping, frame sweeps and pixel
// reads; owns the pending clear flag and the result valid.
// ----------------------------------------------------------------------------
module psfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  psfp_pkg::action_t action,
    input  logic              enabled,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  psfp_pkg::status_t status,
    output psfp_pkg::cmd_t    cmd
);
    import psfp_pkg::*;

    typedef enum logic [8:0] {
        ST_INIT  = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_SCALE = 9'b000000100,
        ST_DIVI  = 9'b000001000,
        ST_DIV   = 9'b000010000,
        ST_WR    = 9'b000100000,
        ST_SWEEP = 9'b001000000,
        ST_DRAIN = 9'b010000000,
        ST_RD    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   clear_pending_reg;
    logic   clear_pending_next;
    logic   tick_clear_reg;
    logic   tick_clear_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // a read also waits while the output register is full and not taken
    assign in_ready  = (state_reg == ST_IDLE)
                       && ((action != ACT_READ) || !out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next         = state_reg;
        clear_pending_next = clear_pending_reg;
        tick_clear_next    = tick_clear_reg;
        out_valid_next     = out_valid_reg;
        cmd                = '0;
        cmd.sweep_clear    = tick_clear_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_POINT:
                        begin
                            if (enabled)
                            begin
                                cmd.pt_start = 1'b1;
                                state_next   = ST_SCALE;
                            end
                        end
                        ACT_TICK:
                        begin
                            if (clear_pending_reg || enabled)
                            begin
                                tick_clear_next    = clear_pending_reg;
                                clear_pending_next = 1'b0;
                                state_next         = ST_SWEEP;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            clear_pending_next = 1'b1;
                        end
                        ACT_READ:
                        begin
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCALE:
            begin
                cmd.pt_scale = 1'b1;
                state_next   = ST_DIVI;
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_WR;
            end
            ST_WR:
            begin
                cmd.pt_write = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last sweep write lands here
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_INIT;
            clear_pending_reg <= 1'b1;
            tick_clear_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clear_pending_reg <= clear_pending_next;
            tick_clear_reg    <= tick_clear_next;
            out_valid_reg     <= out_valid_next;
        end
    end

endmodule

// ===== rtl/psfp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfp_dp: datapath of the phase scope frame plotter
// Frame store memory, sweep counters with fade and axis drawing, two lanes
// of zoom scaling and a reciprocal-multiply division by the constant scale.
// ----------------------------------------------------------------------------
module psfp_dp #(
    parameter int SIDE       = 128,
    parameter int FULL_SCALE = 32767
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  psfp_pkg::cmd_t                       cmd,
    output psfp_pkg::status_t                    status,
    input  logic                                 enabled,
    input  logic [psfp_pkg::ZOOM_W-1:0]          zoom_percent,
    input  logic [psfp_pkg::COLOR_W-1:0]         axis_color,
    input  logic [psfp_pkg::COLOR_W-1:0]         trace_color,
    input  logic signed [psfp_pkg::SAMPLE_W-1:0] left_sample,
    input  logic signed [psfp_pkg::SAMPLE_W-1:0] right_sample,
    input  logic [psfp_pkg::ADDR_IN_W-1:0]       pixel_address,
    output logic [psfp_pkg::COLOR_W-1:0]         pixel_color
);
    import psfp_pkg::*;

    localparam int          HALF   = SIDE / 2;
    localparam int          PIXELS = SIDE * SIDE;
    localparam int          AW     = $clog2(PIXELS);
    localparam int          CRW    = $clog2(SIDE);
    localparam int          HW     = $clog2(HALF + 1);
    localparam int          QW     = $clog2(HALF + 2);
    localparam int          PW     = ZOOM_W + SAMPLE_W;
    localparam int          NUMW   = PW + HW;
    localparam logic [63:0] DEN    = 64'd100 * 64'(FULL_SCALE);
    localparam logic [63:0] OVER   = DEN * 64'(HALF + 1);
    localparam int          SH     = $clog2(OVER);
    localparam logic [63:0] RECIP  = (64'd1 << SH) / DEN;

    // frame store
    logic [COLOR_W-1:0] mem [PIXELS];
    logic [COLOR_W-1:0] mem_rd_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [COLOR_W-1:0] wr_data;

    // sweep
    logic [AW-1:0]      lin_reg;
    logic [CRW-1:0]     row_reg;
    logic [CRW-1:0]     col_reg;
    logic               sw_wr_reg;
    logic [AW-1:0]      sw_addr_reg;
    logic               sw_axis_reg;
    logic [COLOR_W-1:0] sweep_base;
    logic [COLOR_W-1:0] sweep_val;

    // read path
    logic               rd_ok_reg;
    logic [COLOR_W-1:0] pixel_color_reg;

    // point lanes: 0 is x from right, 1 is y from negated left
    logic [SAMPLE_W-1:0] mag    [2];
    logic                neg_in [2];
    logic                neg_reg  [2];
    logic [PW-1:0]       p1_reg   [2];
    logic [NUMW-1:0]     num_reg  [2];
    logic                over_reg [2];
    logic [QW-1:0]       q_reg    [2];
    logic                ok       [2];
    logic [CRW-1:0]      coord    [2];
    logic [AW-1:0]       pt_addr;

    assign status.sweep_last = (lin_reg == AW'(PIXELS - 1));

    assign mag[0]    = right_sample[SAMPLE_W-1] ? (~right_sample + 16'd1) : right_sample;
    assign mag[1]    = left_sample[SAMPLE_W-1] ? (~left_sample + 16'd1) : left_sample;
    assign neg_in[0] = right_sample[SAMPLE_W-1];
    assign neg_in[1] = !left_sample[SAMPLE_W-1];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            ok[i] = !over_reg[i]
                    && (neg_reg[i] ? (32'(q_reg[i]) <= HALF) : (32'(q_reg[i]) < (SIDE - HALF)));
            coord[i] = neg_reg[i] ? (CRW'(HALF) - CRW'(q_reg[i]))
                                  : (CRW'(HALF) + CRW'(q_reg[i]));
        end
    end

    assign pt_addr = AW'(coord[1]) * AW'(SIDE) + AW'(coord[0]);

    assign sweep_base = cmd.sweep_clear ? '0 : mem_rd_reg;
    always_comb
    begin
        if (!enabled)
        begin
            sweep_val = sweep_base;
        end
        else if (sw_axis_reg)
        begin
            sweep_val = axis_color;
        end
        else
        begin
            sweep_val = fade(sweep_base);
        end
    end

    assign rd_addr = cmd.sweep_rd ? lin_reg : AW'(pixel_address);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = lin_reg;
        wr_data = '0;
        if (cmd.init_wr)
        begin
            wr_en = 1'b1;
        end
        else if (sw_wr_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = sw_addr_reg;
            wr_data = sweep_val;
        end
        else if (cmd.pt_write && ok[0] && ok[1])
        begin
            wr_en   = 1'b1;
            wr_addr = pt_addr;
            wr_data = trace_color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_rd_reg <= mem[rd_addr];
    end

    // sweep counters, shared by the reset clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            sw_wr_reg <= 1'b0;
        end
        else
        begin
            sw_wr_reg <= cmd.sweep_rd;
            if (cmd.sweep_rd || cmd.init_wr)
            begin
                if (status.sweep_last)
                begin
                    lin_reg <= '0;
                    row_reg <= '0;
                    col_reg <= '0;
                end
                else
                begin
                    lin_reg <= lin_reg + AW'(1);
                    if (col_reg == CRW'(SIDE - 1))
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + CRW'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + CRW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sw_addr_reg <= lin_reg;
        sw_axis_reg <= (row_reg == CRW'(HALF)) || (col_reg == CRW'(HALF));
        rd_ok_reg   <= (32'(pixel_address) < PIXELS);
        if (cmd.out_load)
        begin
            pixel_color_reg <= rd_ok_reg ? mem_rd_reg : '0;
        end
    end

    assign pixel_color = pixel_color_reg;

    // point mapping: multiply, scale, estimate the quotient with the
    // reciprocal of the scale, then correct the estimate by one compare
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.pt_start)
            begin
                neg_reg[i] <= neg_in[i];
                p1_reg[i]  <= PW'(zoom_percent) * PW'(mag[i]);
            end
            if (cmd.pt_scale)
            begin
                num_reg[i] <= NUMW'(p1_reg[i]) * NUMW'(HALF);
            end
            if (cmd.div_init)
            begin
                over_reg[i] <= (64'(num_reg[i]) >= OVER);
                q_reg[i]    <= QW'((64'(num_reg[i]) * RECIP) >> SH);
            end
            else if (cmd.div_step)
            begin
                // below the bound the estimate is low by at most one
                if (64'(num_reg[i]) >= (64'(q_reg[i]) + 64'd1) * DEN)
                begin
                    q_reg[i] <= q_reg[i] + QW'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/phase_scope_frame_plotter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_scope_frame_plotter_top: stereo phase scope on a square RGB frame
// Plots left/right sample pairs into a SIDE x SIDE frame store; on frame
// ticks applies any pending clear, fades, redraws the axes; read items return pixels.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tuser: action; tdata: samples, address
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: pixel_color
//   cfg       in   cfg_we                         cfg_index, cfg_data
//
// Point item: accept, scale, reciprocal estimate, correction and the pixel write.
// Frame tick: a sweep of all SIDE*SIDE pixels, one pixel a cycle through the store port.
// Read item: accept with the store read, then the output register load.
// After reset a clearing pass zeroes all SIDE*SIDE pixels of the store.
// A read is held off while the output register is full and stalled.
// ----------------------------------------------------------------------------
module phase_scope_frame_plotter_top #(
    parameter int SIDE       = 128,
    parameter int FULL_SCALE = 32767
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // left_sample, right_sample, pixel_address, pad
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // pixel_color
    input  logic        cfg_we,
    input  logic [psfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [psfp_pkg::COLOR_W-1:0]   cfg_data
);
    import psfp_pkg::*;

    logic               enabled_reg;
    logic [ZOOM_W-1:0]  zoom_reg;
    logic [COLOR_W-1:0] axis_reg;
    logic [COLOR_W-1:0] trace_reg;
    cmd_t               cmd;
    status_t            status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= RST_ENABLED;
            zoom_reg    <= RST_ZOOM;
            axis_reg    <= RST_AXIS;
            trace_reg   <= RST_TRACE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLED: enabled_reg <= cfg_data[0];
                CFG_ZOOM:    zoom_reg    <= cfg_data[ZOOM_W-1:0];
                CFG_AXIS:    axis_reg    <= cfg_data;
                CFG_TRACE:   trace_reg   <= cfg_data;
                default:     enabled_reg <= enabled_reg;
            endcase
        end
    end

    psfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .action    (action_t'(s_axis_tuser)),
        .enabled   (enabled_reg),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    psfp_dp #(
        .SIDE       (SIDE),
        .FULL_SCALE (FULL_SCALE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .enabled       (enabled_reg),
        .zoom_percent  (zoom_reg),
        .axis_color    (axis_reg),
        .trace_color   (trace_reg),
        .left_sample   (s_axis_tdata[15:0]),
        .right_sample  (s_axis_tdata[31:16]),
        .pixel_address (s_axis_tdata[45:32]),
        .pixel_color   (m_axis_tdata)
    );

endmodule

// ===== rtl/psfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfp_checker: port-level checks of the phase scope frame plotter
// Result timing against read items, and output hold under stall.
// ----------------------------------------------------------------------------
module psfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready
);
    import psfp_pkg::*;

    logic rd_acc;
    logic other_acc;

    assign rd_acc    = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_READ);
    assign other_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_READ);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        rd_acc |-> ##2 m_axis_tvalid)
        else $error("read item gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        other_acc && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result without a read item");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(rd_acc, 2))
        else $error("result not two cycles after a read item");

endmodule

bind phase_scope_frame_plotter_top psfp_checker u_psfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
